### rtl/core/spdal_pkg.sv
`timescale 1ns / 1ps

package spdal_pkg;

  // Pool size default, result limit and fixed field widths
  localparam int SLOT_COUNT_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int OP_W           = 2;
  localparam int SLOT_W         = 3;
  localparam int COUNT_OUT_W    = 4;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MERGE,
    ST_PREP,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic single;
    logic merge_init;
    logic merge_step;
    logic merge_finish;
    logic emit_init;
    logic emit_push;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            dirty;
    logic            merge_done;
    logic            out_free;
    logic            emit_last;
  } dp_stat_t;

endpackage

### rtl/core/slot_pool_with_deferred_active_list.sv
`timescale 1ns / 1ps
// Slot pool with a deferred, double-buffered active list.
// Request channel (in_valid/in_ready, op, slot): op 0 creates a slot, op 1
// destroys slot, op 2 refreshes the active list and reads it out.
// Result channel (out_valid/out_ready, ok, slot_index, active_count, last):
// create and destroy give one result; refresh gives one result per list
// entry (at most 8), or one ok=0 result when the list is empty. last marks
// the final result of each request.
// Create and destroy: the request is decoded in EXEC and the result is
// loaded into the output register once that is free; the next request is
// taken back in IDLE. Refresh: decode in EXEC, then when the list is dirty
// a merge walk (one list buffer read per cycle), then PREP to prime the
// registered read of the list buffer, then one result per cycle while the
// receiver takes them.
// One request is in flight at a time; in_ready is high only when idle.
// The output register holds a result while the receiver stalls; the block
// waits before loading the next result until that one is taken.
// Reset clears all alive marks, both counts and the dirty flag; the list
// buffers need no clearing. Results resume the cycle after out_ready rises.
module slot_pool_with_deferred_active_list
  import spdal_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic [SLOT_W-1:0]      slot,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   ok,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [COUNT_OUT_W-1:0] active_count,
  output logic                   last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spdal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spdal_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .slot_index   (slot_index),
    .active_count (active_count),
    .last         (last)
  );

  // A taken request keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous request in flight");

  // Failures and empty lists are single results
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> last)
    else $error("failed result not marked last");

  // No request is taken in the middle of a list readout
  a_no_accept_mid_list: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_push && !stat.emit_last) |=> !in_ready)
    else $error("request taken during list readout");

endmodule

### rtl/core/spdal_ctrl.sv
`timescale 1ns / 1ps

module spdal_ctrl
  import spdal_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.op == OP_REFRESH) begin
          if (stat.dirty) begin
            cmd.merge_init = 1'b1;
            state_next     = ST_MERGE;
          end else begin
            state_next = ST_PREP;
          end
        end else if (stat.out_free) begin
          cmd.single = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MERGE: begin
        if (stat.merge_done) begin
          cmd.merge_finish = 1'b1;
          state_next       = ST_PREP;
        end else begin
          cmd.merge_step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.emit_init = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_push = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/spdal_dpath.sv
`timescale 1ns / 1ps

module spdal_dpath
  import spdal_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [OP_W-1:0]        op,
  input  logic [SLOT_W-1:0]      slot,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   ok,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [COUNT_OUT_W-1:0] active_count,
  output logic                   last
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int XW = SW + SLOT_W;
  localparam logic [CW-1:0] FULL = CW'(SLOT_COUNT);

  // Latched request
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] slot_q;

  // Pool state
  logic [SLOT_COUNT-1:0] alive;
  logic [SW-1:0]         buf_a [SLOT_COUNT];
  logic [SW-1:0]         buf_b [SLOT_COUNT];
  logic                  cur_b;
  logic [CW-1:0]         active_total;
  logic [CW-1:0]         pending_total;
  logic                  dirty;

  // Lowest free slot, registered
  logic          free_any_c;
  logic [SW-1:0] free_slot_c;
  logic          free_any;
  logic [SW-1:0] free_slot;

  // Walk state
  logic [CW-1:0] rd_idx;
  logic          pipe_vld;
  logic [CW-1:0] emit_idx;
  logic [CW-1:0] emit_n;
  logic          emit_last;

  // Buffer ports
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] rdata_a;
  logic [SW-1:0] rdata_b;
  logic [SW-1:0] cur_rdata;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  // Operation decode
  logic          create_ok;
  logic [XW-1:0] slot_ext;
  logic          slot_in_range;
  logic          entry_keep;
  logic          append;

  // Result assembly
  logic              load;
  logic              res_ok;
  logic [SLOT_W-1:0] res_idx;
  logic              res_last;
  logic [SW-1:0]     idx_sw;
  logic [XW-1:0]     idx_ext;
  logic [CW+COUNT_OUT_W-1:0] cnt_ext;

  // Find lowest free slot
  always_comb begin
    free_any_c  = 1'b0;
    free_slot_c = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_any_c  = 1'b1;
        free_slot_c = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    free_any  <= free_any_c;
    free_slot <= free_slot_c;
  end

  // Decode
  assign create_ok     = (active_total < FULL) && (pending_total < FULL) && free_any;
  assign slot_ext      = {{SW{1'b0}}, slot_q};
  assign slot_in_range = slot_ext < XW'(SLOT_COUNT);
  assign cur_rdata     = cur_b ? rdata_b : rdata_a;
  assign entry_keep    = (CW'(cur_rdata) < FULL) ? alive[cur_rdata] : 1'b0;
  assign append        = cmd.merge_step && pipe_vld && entry_keep && (pending_total < FULL);

  // Emit bounds
  always_comb begin
    if (int'(active_total) > MAX_RESULTS) begin
      emit_n = CW'(MAX_RESULTS);
    end else begin
      emit_n = active_total;
    end
  end
  assign emit_last = (emit_n == '0) || (emit_idx == emit_n - CW'(1));

  // Buffer read address
  always_comb begin
    if (cmd.merge_step) begin
      rd_addr = SW'(rd_idx);
    end else if (cmd.emit_init) begin
      rd_addr = '0;
    end else if (cmd.emit_push) begin
      rd_addr = SW'(emit_idx + CW'(1));
    end else begin
      rd_addr = SW'(emit_idx);
    end
  end

  // Buffer write: new slot on create, kept entry on merge
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SW'(pending_total);
    wr_data = free_slot;
    if (cmd.single && (op_q == OP_CREATE) && create_ok) begin
      wr_en = 1'b1;
    end else if (append) begin
      wr_en   = 1'b1;
      wr_data = cur_rdata;
    end
  end

  // List buffers, pending one is written
  always_ff @(posedge clk) begin
    rdata_a <= buf_a[rd_addr];
    rdata_b <= buf_b[rd_addr];
    if (wr_en && cur_b) begin
      buf_a[wr_addr] <= wr_data;
    end
    if (wr_en && !cur_b) begin
      buf_b[wr_addr] <= wr_data;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op;
      slot_q <= slot;
    end
  end

  // Pool control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alive         <= '0;
      cur_b         <= 1'b0;
      active_total  <= '0;
      pending_total <= '0;
      dirty         <= 1'b0;
      rd_idx        <= '0;
      pipe_vld      <= 1'b0;
      emit_idx      <= '0;
    end else begin
      if (cmd.single && (op_q == OP_CREATE) && create_ok) begin
        alive[free_slot] <= 1'b1;
        pending_total    <= pending_total + CW'(1);
        dirty            <= 1'b1;
      end
      if (cmd.single && (op_q == OP_DESTROY) && slot_in_range) begin
        alive[slot_ext[SW-1:0]] <= 1'b0;
        dirty                   <= 1'b1;
      end
      if (cmd.merge_init) begin
        rd_idx   <= '0;
        pipe_vld <= 1'b0;
      end
      // one read issued and one entry checked per cycle
      if (cmd.merge_step) begin
        if (rd_idx != active_total) begin
          rd_idx   <= rd_idx + CW'(1);
          pipe_vld <= 1'b1;
        end else begin
          pipe_vld <= 1'b0;
        end
      end
      if (append) begin
        pending_total <= pending_total + CW'(1);
      end
      if (cmd.merge_finish) begin
        active_total  <= pending_total;
        pending_total <= '0;
        dirty         <= 1'b0;
        cur_b         <= ~cur_b;
      end
      if (cmd.emit_init) begin
        emit_idx <= '0;
      end
      if (cmd.emit_push) begin
        emit_idx <= emit_idx + CW'(1);
      end
    end
  end

  // Result fields
  always_comb begin
    res_ok   = 1'b0;
    idx_sw   = '0;
    res_last = 1'b1;
    if (cmd.emit_push) begin
      res_ok   = emit_n != '0;
      idx_sw   = (emit_n != '0) ? cur_rdata : '0;
      res_last = emit_last;
    end else begin
      case (op_q)
        OP_CREATE: begin
          res_ok = create_ok;
          idx_sw = create_ok ? free_slot : '0;
        end
        OP_DESTROY: begin
          res_ok = slot_in_range;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  assign idx_ext = {{SLOT_W{1'b0}}, idx_sw};
  assign res_idx = (!cmd.emit_push && (op_q == OP_DESTROY)) ? slot_q : idx_ext[SLOT_W-1:0];
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, active_total};

  // Output register
  assign load = cmd.single || cmd.emit_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok           <= res_ok;
      slot_index   <= res_idx;
      active_count <= cnt_ext[COUNT_OUT_W-1:0];
      last         <= res_last;
    end
  end

  // Status
  assign stat.op         = op_q;
  assign stat.dirty      = dirty;
  assign stat.merge_done = (rd_idx == active_total) && !pipe_vld;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.emit_last  = emit_last;

endmodule
